[design/jsv_pkg.sv]
package jsv_pkg;

	typedef enum logic [4:0] {
		LM_VALUE,
		LM_ARR_FIRST,
		LM_OBJ_FIRST,
		LM_KEY,
		LM_COLON,
		LM_AFTER,
		LM_STR,
		LM_STR_ESC,
		LM_KSTR,
		LM_KSTR_ESC,
		LM_N_MINUS,
		LM_N_ZERO,
		LM_N_INT,
		LM_N_DOT,
		LM_N_FRAC,
		LM_N_E,
		LM_N_ESIGN,
		LM_N_EXP,
		LM_LIT
	} lex_mode_t;

	typedef enum logic [4:0] {
		BC_WS,
		BC_QUOTE,
		BC_BSLASH,
		BC_MINUS,
		BC_PLUS,
		BC_ZERO,
		BC_DIGIT,
		BC_DOT,
		BC_EXP,
		BC_LBRK,
		BC_RBRK,
		BC_LBRC,
		BC_RBRC,
		BC_COMMA,
		BC_COLON,
		BC_LIT_T,
		BC_LIT_F,
		BC_LIT_N,
		BC_OTHER
	} byte_cls_t;

	localparam logic KIND_ARRAY  = 1'b0;
	localparam logic KIND_OBJECT = 1'b1;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ctl;
		byte_cls_t  cls;
	} item_t;

	typedef struct packed {
		logic is_valid;
		logic depth_overflow;
	} result_t;

	function automatic byte_cls_t classify(input logic [7:0] b);
		byte_cls_t c;
		c = BC_OTHER;
		unique case (b) inside
			8'h20, 8'h09, 8'h0A, 8'h0D: c = BC_WS;
			8'h22:                      c = BC_QUOTE;   // "
			8'h5C:                      c = BC_BSLASH;
			8'h2D:                      c = BC_MINUS;
			8'h2B:                      c = BC_PLUS;
			8'h30:                      c = BC_ZERO;
			[8'h31:8'h39]:              c = BC_DIGIT;
			8'h2E:                      c = BC_DOT;
			8'h65, 8'h45:               c = BC_EXP;     // e, E
			8'h5B:                      c = BC_LBRK;
			8'h5D:                      c = BC_RBRK;
			8'h7B:                      c = BC_LBRC;
			8'h7D:                      c = BC_RBRC;
			8'h2C:                      c = BC_COMMA;
			8'h3A:                      c = BC_COLON;
			8'h74:                      c = BC_LIT_T;
			8'h66:                      c = BC_LIT_F;
			8'h6E:                      c = BC_LIT_N;
			default:                    c = BC_OTHER;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		logic [2:0] n;
		unique case (kind)
			LIT_TRUE:  n = 3'd4;
			LIT_FALSE: n = 3'd5;
			LIT_NULL:  n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (kind)
			LIT_TRUE: begin
				unique case (idx)
					3'd0:    ch = 8'h74;
					3'd1:    ch = 8'h72;
					3'd2:    ch = 8'h75;
					3'd3:    ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				unique case (idx)
					3'd0:    ch = 8'h66;
					3'd1:    ch = 8'h61;
					3'd2:    ch = 8'h6C;
					3'd3:    ch = 8'h73;
					3'd4:    ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				unique case (idx)
					3'd0:    ch = 8'h6E;
					3'd1:    ch = 8'h75;
					3'd2:    ch = 8'h6C;
					3'd3:    ch = 8'h6C;
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[design/jsv_fifo.sv]
module jsv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/jsv_ram.sv]
module jsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/jsv_front.sv]
module jsv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          q_full,
	output logic          q_push,
	output jsv_pkg::item_t q_item
);
	import jsv_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= data_byte;
			item_s1.last <= last_byte;
			item_s1.ctl  <= (data_byte < 8'h20);
			item_s1.cls  <= classify(data_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

endmodule

[design/jsv_back.sv]
module jsv_back #(
	parameter int MAX_NESTING = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jsv_pkg::item_t   item,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic             res_full,
	output logic             res_push,
	output jsv_pkg::result_t res_data
);
	import jsv_pkg::*;

	localparam int DW = $clog2(MAX_NESTING + 1);
	localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NESTING);

	lex_mode_t     mode_q, h_mode, sv_mode, av_mode;
	logic [2:0]    lidx_q, h_lidx;
	logic [1:0]    lkind_q, h_lkind, sv_lkind;
	logic [DW-1:0] depth_q, h_depth, depth_nxt, wr_pos, rd_pos;
	logic          top_q, under, byp_q, byp_data_q, ram_rd;
	logic          err_q, ovf_q, h_err, h_ovf;
	logic          h_push, h_pop, h_kind;
	logic          sv_fail, sv_ovf, sv_push, sv_kind, sv_lit;
	logic          av_fail, av_pop;
	logic          fire, is_digit, ram_we;
	logic [2:0]    llen;

	assign fire     = !q_empty && !(item.last && res_full);
	assign q_pop    = fire;
	assign is_digit = (item.cls == BC_ZERO) || (item.cls == BC_DIGIT);
	assign llen     = lit_len(lkind_q);
	// entry just below the top; bypass covers a write to the same slot last cycle
	assign under    = byp_q ? byp_data_q : ram_rd;

	// start of a value
	always_comb begin
		sv_mode  = mode_q;
		sv_fail  = 1'b0;
		sv_ovf   = 1'b0;
		sv_push  = 1'b0;
		sv_kind  = KIND_ARRAY;
		sv_lit   = 1'b0;
		sv_lkind = lkind_q;
		unique case (item.cls) inside
			BC_WS:    sv_mode = mode_q;
			BC_QUOTE: sv_mode = LM_STR;
			BC_LIT_T: begin sv_lit = 1'b1; sv_lkind = LIT_TRUE;  sv_mode = LM_LIT; end
			BC_LIT_F: begin sv_lit = 1'b1; sv_lkind = LIT_FALSE; sv_mode = LM_LIT; end
			BC_LIT_N: begin sv_lit = 1'b1; sv_lkind = LIT_NULL;  sv_mode = LM_LIT; end
			BC_MINUS: sv_mode = LM_N_MINUS;
			BC_ZERO:  sv_mode = LM_N_ZERO;
			BC_DIGIT: sv_mode = LM_N_INT;
			BC_LBRK, BC_LBRC: begin
				if (depth_q >= DEPTH_MAX) begin
					sv_ovf  = 1'b1;
					sv_fail = 1'b1;
				end else begin
					sv_push = 1'b1;
					sv_kind = (item.cls == BC_LBRC) ? KIND_OBJECT : KIND_ARRAY;
					sv_mode = (item.cls == BC_LBRC) ? LM_OBJ_FIRST : LM_ARR_FIRST;
				end
			end
			default: sv_fail = 1'b1;
		endcase
	end

	// byte after a complete value
	always_comb begin
		av_mode = LM_AFTER;
		av_fail = 1'b0;
		av_pop  = 1'b0;
		if (item.cls != BC_WS) begin
			if (depth_q == '0) begin
				av_fail = 1'b1;
			end else if (item.cls == BC_COMMA) begin
				av_mode = top_q ? LM_KEY : LM_VALUE;
			end else if ((item.cls == BC_RBRK && top_q == KIND_ARRAY) ||
			             (item.cls == BC_RBRC && top_q == KIND_OBJECT)) begin
				av_pop = 1'b1;
			end else begin
				av_fail = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		h_mode  = mode_q;
		h_lidx  = lidx_q;
		h_lkind = lkind_q;
		h_err   = err_q;
		h_ovf   = ovf_q;
		h_push  = 1'b0;
		h_pop   = 1'b0;
		h_kind  = KIND_ARRAY;
		if (!err_q) begin
			unique case (mode_q) inside
				LM_VALUE, LM_ARR_FIRST: begin
					if (mode_q == LM_ARR_FIRST && item.cls == BC_RBRK) begin
						h_pop  = 1'b1;
						h_mode = LM_AFTER;
					end else begin
						h_mode = sv_mode;
						h_err  = sv_fail;
						h_ovf  = sv_ovf;
						h_push = sv_push;
						h_kind = sv_kind;
						if (sv_lit) begin
							h_lkind = sv_lkind;
							h_lidx  = 3'd1;
						end
					end
				end
				LM_OBJ_FIRST, LM_KEY: begin
					if (item.cls == BC_WS) begin
						h_mode = mode_q;
					end else if (item.cls == BC_QUOTE) begin
						h_mode = LM_KSTR;
					end else if (item.cls == BC_RBRC && mode_q == LM_OBJ_FIRST) begin
						h_pop  = 1'b1;
						h_mode = LM_AFTER;
					end else begin
						h_err = 1'b1;
					end
				end
				LM_COLON: begin
					if (item.cls == BC_COLON) h_mode = LM_VALUE;
					else if (item.cls != BC_WS) h_err = 1'b1;
				end
				LM_AFTER: begin
					h_mode = av_mode;
					h_err  = av_fail;
					h_pop  = av_pop;
				end
				LM_STR, LM_KSTR: begin
					if (item.cls == BC_BSLASH) begin
						h_mode = (mode_q == LM_STR) ? LM_STR_ESC : LM_KSTR_ESC;
					end else if (item.cls == BC_QUOTE) begin
						h_mode = (mode_q == LM_STR) ? LM_AFTER : LM_COLON;
					end else if (item.ctl) begin
						h_err = 1'b1;
					end
				end
				LM_STR_ESC:  h_mode = LM_STR;
				LM_KSTR_ESC: h_mode = LM_KSTR;
				LM_N_MINUS: begin
					if (item.cls == BC_ZERO) h_mode = LM_N_ZERO;
					else if (item.cls == BC_DIGIT) h_mode = LM_N_INT;
					else h_err = 1'b1;
				end
				LM_N_ZERO, LM_N_INT, LM_N_FRAC: begin
					if (mode_q != LM_N_ZERO && is_digit) begin
						h_mode = mode_q;
					end else if (item.cls == BC_DOT && mode_q != LM_N_FRAC) begin
						h_mode = LM_N_DOT;
					end else if (item.cls == BC_EXP) begin
						h_mode = LM_N_E;
					end else begin
						// number ends; this byte counts as the one after the value
						h_mode = av_mode;
						h_err  = av_fail;
						h_pop  = av_pop;
					end
				end
				LM_N_DOT: begin
					if (is_digit) h_mode = LM_N_FRAC;
					else h_err = 1'b1;
				end
				LM_N_E: begin
					if (item.cls == BC_PLUS || item.cls == BC_MINUS) h_mode = LM_N_ESIGN;
					else if (is_digit) h_mode = LM_N_EXP;
					else h_err = 1'b1;
				end
				LM_N_ESIGN: begin
					if (is_digit) h_mode = LM_N_EXP;
					else h_err = 1'b1;
				end
				LM_N_EXP: begin
					if (!is_digit) begin
						h_mode = av_mode;
						h_err  = av_fail;
						h_pop  = av_pop;
					end
				end
				LM_LIT: begin
					if (lidx_q < llen && item.data == lit_char(lkind_q, lidx_q)) begin
						h_lidx = lidx_q + 3'd1;
						if (lidx_q + 3'd1 >= llen) h_mode = LM_AFTER;
					end else begin
						h_err = 1'b1;
					end
				end
				default: h_err = 1'b1;
			endcase
		end
	end

	assign h_depth = h_push ? depth_q + DW'(1) : (h_pop ? depth_q - DW'(1) : depth_q);

	// outputs
	always_comb begin
		res_push                = fire && item.last;
		res_data.is_valid       = !h_err && (h_depth == '0) &&
		                          (h_mode == LM_AFTER || h_mode == LM_N_ZERO ||
		                           h_mode == LM_N_INT || h_mode == LM_N_FRAC ||
		                           h_mode == LM_N_EXP);
		res_data.depth_overflow = h_ovf;
		ram_we                  = fire && !item.last && h_push && (depth_q != '0);
		wr_pos                  = depth_q - DW'(1);
		depth_nxt               = fire ? (item.last ? '0 : h_depth) : depth_q;
		rd_pos                  = depth_nxt - DW'(2);
	end

	// old top moves into memory on a push; the register keeps the live top
	jsv_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NESTING)
	) u_stack (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_pos[AW-1:0]),
		.wr_data (top_q),
		.rd_addr (rd_pos[AW-1:0]),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= top_q;
		if (fire && !item.last) begin
			if (h_push) top_q <= h_kind;
			else if (h_pop) top_q <= under;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= LM_VALUE;
			lidx_q  <= '0;
			lkind_q <= '0;
			depth_q <= '0;
			err_q   <= 1'b0;
			ovf_q   <= 1'b0;
			byp_q   <= 1'b0;
		end else begin
			byp_q   <= ram_we;
			depth_q <= depth_nxt;
			if (fire) begin
				if (item.last) begin
					mode_q  <= LM_VALUE;
					lidx_q  <= '0;
					lkind_q <= '0;
					err_q   <= 1'b0;
					ovf_q   <= 1'b0;
				end else begin
					mode_q  <= h_mode;
					lidx_q  <= h_lidx;
					lkind_q <= h_lkind;
					err_q   <= h_err;
					ovf_q   <= h_ovf;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("nesting depth past stack size");

	a_ovf_err: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> err_q)
		else $error("overflow without error flag");

	a_doc_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.last) |=> (depth_q == '0 && !err_q && !ovf_q && mode_q == LM_VALUE))
		else $error("state not cleared after last byte");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into full queue");
`endif

endmodule

[design/json_syntax_validator_top.sv]
// Result: the checker writes the result of a last byte into the result queue, which drives the result ports.
// Throughput: one byte per cycle, held while a last byte meets a full result queue.
// Stack: top entry in a register, lower entries in a RAM with a one-slot write bypass.
// Reset: arst_n clears queues and lexer state; the stack RAM is not cleared.
// Stack entries are written before they are read, so no clearing pass is needed.
module json_syntax_validator_top #(
	parameter int MAX_NESTING = 32,
	parameter int FIFO_DEPTH  = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic       is_valid,
	output logic       depth_overflow
);
	import jsv_pkg::*;

	item_t   f_item, b_item;
	logic    f_push, q_full, q_empty, q_pop;
	logic    res_full, res_push;
	result_t res_in, res_out;

	jsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_item    (f_item)
	);

	jsv_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (FIFO_DEPTH)
	) u_byte_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (b_item),
		.empty   (q_empty)
	);

	jsv_back #(
		.MAX_NESTING (MAX_NESTING)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (b_item),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_in)
	);

	jsv_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign is_valid       = res_out.is_valid;
	assign depth_overflow = res_out.depth_overflow;

endmodule
